@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port-level checker lbpm_chk.
// Pulled in by `include; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define LBPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lbpm: implication check failed");

// next-cycle implication, quiet while reset is held
`define LBPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lbpm: next-cycle check failed");

`endif

@@ rtl/core/lbpm_pkg.sv @@
// Shared types and constants for the light bar pair matcher.
// No dependencies.
`timescale 1ns / 1ps

package lbpm_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STAGES    = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_FLOOR = 3'd0,
        CFG_RATIO_CEIL  = 3'd1,
        CFG_SLOPE_MAX   = 3'd2,
        CFG_NEAR_MULT   = 3'd3,
        CFG_FAR_MULT    = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_RATIO_FLOOR = 16'd13107;
    localparam logic [CFG_W-1:0] RST_RATIO_CEIL  = 16'd65535;
    localparam logic [CFG_W-1:0] RST_SLOPE_MAX   = 16'd77;
    localparam logic [CFG_W-1:0] RST_NEAR_MULT   = 16'd512;
    localparam logic [CFG_W-1:0] RST_FAR_MULT    = 16'd2048;

    typedef struct packed {
        logic [CFG_W-1:0] ratio_floor;
        logic [CFG_W-1:0] ratio_ceil;
        logic [CFG_W-1:0] slope_max;
        logic [CFG_W-1:0] near_mult;
        logic [CFG_W-1:0] far_mult;
    } t_cfg;

    // per-stage load enables from the handshake chain
    typedef struct packed {
        logic [STAGES-1:0] adv;
    } t_pipe_ctl;

endpackage

@@ rtl/core/lbpm_datapath.sv @@
// Five-stage datapath of the pair matcher: areas, distances and all tests.
// Depends on lbpm_pkg; stage loads come from the top-level handshake chain.
`timescale 1ns / 1ps

module lbpm_datapath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                      i_clk,
    input  lbpm_pkg::t_pipe_ctl       i_ctl,
    input  lbpm_pkg::t_cfg            i_cfg,
    input  logic [8*COORD_WIDTH-1:0]  i_data,
    output logic                      o_is_pair
);

    localparam int W   = COORD_WIDTH;
    localparam int AW  = 2 * W;
    localparam int PW  = W + lbpm_pkg::CFG_W;
    localparam int HW  = (PW + 1) / 2;
    localparam int LW  = PW - HW;
    localparam int SQW = 2 * PW;
    localparam int RW  = AW + lbpm_pkg::CFG_W;
    localparam int DW  = AW + 1;

    // stage 1: areas, center deltas, side extremes
    logic [W-1:0]  w_x1, w_y1, w_w1, w_h1, w_x2, w_y2, w_w2, w_h2;
    logic [W-1:0]  w_sh1, w_sh2, w_lg1, w_lg2;
    logic [AW-1:0] r1_a1, r1_a2;
    logic [W-1:0]  r1_dx, r1_dy, r1_m, r1_bl;

    always_comb begin
        w_x1  = i_data[0*W +: W];
        w_y1  = i_data[1*W +: W];
        w_w1  = i_data[2*W +: W];
        w_h1  = i_data[3*W +: W];
        w_x2  = i_data[4*W +: W];
        w_y2  = i_data[5*W +: W];
        w_w2  = i_data[6*W +: W];
        w_h2  = i_data[7*W +: W];
        w_sh1 = (w_w1 < w_h1) ? w_w1 : w_h1;
        w_lg1 = (w_w1 < w_h1) ? w_h1 : w_w1;
        w_sh2 = (w_w2 < w_h2) ? w_w2 : w_h2;
        w_lg2 = (w_w2 < w_h2) ? w_h2 : w_w2;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_a1 <= AW'(w_w1) * AW'(w_h1);
            r1_a2 <= AW'(w_w2) * AW'(w_h2);
            r1_dx <= (w_x1 > w_x2) ? w_x1 - w_x2 : w_x2 - w_x1;
            r1_dy <= (w_y1 > w_y2) ? w_y1 - w_y2 : w_y2 - w_y1;
            r1_m  <= (w_sh1 > w_sh2) ? w_sh1 : w_sh2;
            r1_bl <= (w_lg1 > w_lg2) ? w_lg1 : w_lg2;
        end
    end

    // stage 2: order the areas, squares and bound products
    logic          r2_ok;
    logic [AW-1:0] r2_s, r2_l, r2_dx2, r2_dy2, r2_bl2;
    logic [PW-1:0] r2_plo, r2_phi, r2_sdx;
    logic [W-1:0]  r2_dy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r2_ok  <= (r1_a1 != '0) && (r1_a2 != '0) && (r1_dx != '0);
            r2_s   <= (r1_a1 < r1_a2) ? r1_a1 : r1_a2;
            r2_l   <= (r1_a1 < r1_a2) ? r1_a2 : r1_a1;
            r2_dx2 <= AW'(r1_dx) * AW'(r1_dx);
            r2_dy2 <= AW'(r1_dy) * AW'(r1_dy);
            r2_bl2 <= AW'(r1_bl) * AW'(r1_bl);
            r2_plo <= PW'(r1_m) * PW'(i_cfg.near_mult);
            r2_phi <= PW'(r1_m) * PW'(i_cfg.far_mult);
            r2_sdx <= PW'(r1_dx) * PW'(i_cfg.slope_max);
            r2_dy  <= r1_dy;
        end
    end

    // stage 3: ratio products, d2, slope test, split squares of the bounds
    logic              r3_ok;
    logic [RW-1:0]     r3_rmin, r3_rmax;
    logic [AW-1:0]     r3_s, r3_bl2;
    logic [DW-1:0]     r3_d2;
    logic [2*LW-1:0]   r3_lo_hh, r3_hi_hh;
    logic [PW-1:0]     r3_lo_hl, r3_hi_hl;
    logic [2*HW-1:0]   r3_lo_ll, r3_hi_ll;
    logic              w_slope_ok;

    assign w_slope_ok = PW'({r2_dy, 8'b0}) <= r2_sdx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r3_ok    <= r2_ok && w_slope_ok;
            r3_rmin  <= RW'(i_cfg.ratio_floor) * RW'(r2_l);
            r3_rmax  <= RW'(i_cfg.ratio_ceil) * RW'(r2_l);
            r3_s     <= r2_s;
            r3_bl2   <= r2_bl2;
            r3_d2    <= DW'(r2_dx2) + DW'(r2_dy2);
            r3_lo_hh <= (2*LW)'(r2_plo[PW-1:HW]) * (2*LW)'(r2_plo[PW-1:HW]);
            r3_lo_hl <= PW'(r2_plo[PW-1:HW]) * PW'(r2_plo[HW-1:0]);
            r3_lo_ll <= (2*HW)'(r2_plo[HW-1:0]) * (2*HW)'(r2_plo[HW-1:0]);
            r3_hi_hh <= (2*LW)'(r2_phi[PW-1:HW]) * (2*LW)'(r2_phi[PW-1:HW]);
            r3_hi_hl <= PW'(r2_phi[PW-1:HW]) * PW'(r2_phi[HW-1:0]);
            r3_hi_ll <= (2*HW)'(r2_phi[HW-1:0]) * (2*HW)'(r2_phi[HW-1:0]);
        end
    end

    // stage 4: area and long-side tests, recombine squares
    logic           r4_ok;
    logic [SQW-1:0] r4_sqlo, r4_sqhi;
    logic [DW-1:0]  r4_d2;
    logic [RW-1:0]  w_s15;
    logic           w_area_ok, w_long_ok;

    always_comb begin
        w_s15     = RW'({r3_s, 15'b0});
        w_area_ok = (r3_rmin < w_s15) && (w_s15 < r3_rmax);
        w_long_ok = (DW'(r3_bl2) < r3_d2)
                 && ((DW + 3)'(r3_d2) < (DW + 3)'({r3_bl2, 4'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r4_ok   <= r3_ok && w_area_ok && w_long_ok;
            r4_sqlo <= (SQW'(r3_lo_hh) << (2*HW)) + (SQW'(r3_lo_hl) << (HW+1))
                     + SQW'(r3_lo_ll);
            r4_sqhi <= (SQW'(r3_hi_hh) << (2*HW)) + (SQW'(r3_hi_hl) << (HW+1))
                     + SQW'(r3_hi_ll);
            r4_d2   <= r3_d2;
        end
    end

    // stage 5: distance against the short-side bounds, in Q.16 squared units
    logic [SQW-1:0] w_d2s;
    logic           r5_is_pair;

    assign w_d2s = SQW'({r4_d2, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r5_is_pair <= r4_ok && (r4_sqlo < w_d2s) && (w_d2s < r4_sqhi);
        end
    end

    assign o_is_pair = r5_is_pair;

endmodule

@@ rtl/core/light_bar_pair_match_unit.sv @@
// Light bar pair matcher: handshake chain, config registers, datapath.
// Depends on lbpm_pkg and lbpm_datapath.
// m_axis_tvalid rises once an accepted input word has moved through every
// stage register, and the result word leaves while m_axis_tready is high.
// Throughput: one word per cycle; s_axis_tready drops only when all five
// stages are full behind a stalled result. Reset (sync, active low) clears
// all stage valids and loads register defaults.
`timescale 1ns / 1ps

module light_bar_pair_match_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lbpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lbpm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_center_x, first_center_y, first_width, first_height,
    // second_center_x, second_center_y, second_width, second_height
    input  logic [8*COORD_WIDTH-1:0]           s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // is_pair, then 7 zero bits
    output logic [7:0]                         m_axis_tdata
);

    localparam int S = lbpm_pkg::STAGES;

    lbpm_pkg::t_cfg      r_cfg;
    lbpm_pkg::t_pipe_ctl w_ctl;
    logic [S-1:0]        r_vld, n_vld;
    logic                w_is_pair;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio_floor <= lbpm_pkg::RST_RATIO_FLOOR;
            r_cfg.ratio_ceil  <= lbpm_pkg::RST_RATIO_CEIL;
            r_cfg.slope_max   <= lbpm_pkg::RST_SLOPE_MAX;
            r_cfg.near_mult   <= lbpm_pkg::RST_NEAR_MULT;
            r_cfg.far_mult    <= lbpm_pkg::RST_FAR_MULT;
        end else if (i_cfg_we) begin
            unique case (lbpm_pkg::t_cfg_idx'(i_cfg_idx))
                lbpm_pkg::CFG_RATIO_FLOOR: r_cfg.ratio_floor <= i_cfg_data;
                lbpm_pkg::CFG_RATIO_CEIL:  r_cfg.ratio_ceil  <= i_cfg_data;
                lbpm_pkg::CFG_SLOPE_MAX:   r_cfg.slope_max   <= i_cfg_data;
                lbpm_pkg::CFG_NEAR_MULT:   r_cfg.near_mult   <= i_cfg_data;
                lbpm_pkg::CFG_FAR_MULT:    r_cfg.far_mult    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        w_ctl.adv[S-1] = !r_vld[S-1] || m_axis_tready;
        for (int k = S - 2; k >= 0; k--) begin
            w_ctl.adv[k] = !r_vld[k] || w_ctl.adv[k+1];
        end
        n_vld = r_vld;
        if (w_ctl.adv[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < S; k++) begin
            if (w_ctl.adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    lbpm_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_cfg     (r_cfg),
        .i_data    (s_axis_tdata),
        .o_is_pair (w_is_pair)
    );

    assign s_axis_tready = w_ctl.adv[0];
    assign m_axis_tvalid = r_vld[S-1];
    assign m_axis_tdata  = {7'b0, w_is_pair};

endmodule

@@ rtl/core/lbpm_chk.sv @@
// Port-level checker for light_bar_pair_match_unit, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbpm_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tready,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata
);

    // a stalled result word stays put
    `LBPM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    `LBPM_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata))

    // input back-pressure only while a result word is stalled
    `LBPM_ASSERT_IMP(a_bp_cause, i_clk, i_rst_n, !i_s_tready, i_m_tvalid && !i_m_tready)

    // pad bits of the result word stay clear
    `LBPM_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[7:1] == 7'b0)

endmodule

bind light_bar_pair_match_unit lbpm_chk u_lbpm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

@@ bench/lbpm_pair_checker.sv @@
// Scoreboard for the light bar pair matcher: mirrors the config registers,
// predicts is_pair for every accepted input word and checks the result words.
// Depends on lbpm_pkg.
`timescale 1ns / 1ps

module lbpm_pair_checker #(
    parameter int CW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lbpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbpm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [8*CW-1:0]                i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_data,
    output int                             o_results,
    output int                             o_pairs,
    output int                             o_errors
);
    import lbpm_pkg::*;

    localparam int LONG_SPAN = 4;
    localparam int SHOWN_ERRORS = 10;

    t_cfg cfg_mirror;
    bit   pending_pairs[$];

    // all arithmetic at 128 bits so no product can wrap
    function automatic bit judge_pair(input logic [8*CW-1:0] w, input t_cfg c);
        logic [127:0] x1, y1, w1, h1, x2, y2, w2, h2;
        logic [127:0] a1, a2, sm, lg, dx, dy, d2, d2s, m, bl, lim;
        x1 = 128'(w[0*CW +: CW]);
        y1 = 128'(w[1*CW +: CW]);
        w1 = 128'(w[2*CW +: CW]);
        h1 = 128'(w[3*CW +: CW]);
        x2 = 128'(w[4*CW +: CW]);
        y2 = 128'(w[5*CW +: CW]);
        w2 = 128'(w[6*CW +: CW]);
        h2 = 128'(w[7*CW +: CW]);
        a1 = w1 * h1;
        a2 = w2 * h2;
        if (a1 == 0 || a2 == 0) return 1'b0;
        sm = (a1 < a2) ? a1 : a2;
        lg = (a1 < a2) ? a2 : a1;
        if (!(c.ratio_floor * lg < (sm << 15))) return 1'b0;
        if (!((sm << 15) < c.ratio_ceil * lg)) return 1'b0;
        dx = (x1 > x2) ? x1 - x2 : x2 - x1;
        dy = (y1 > y2) ? y1 - y2 : y2 - y1;
        if (dx == 0) return 1'b0;
        if (dy * 256 > c.slope_max * dx) return 1'b0;
        d2  = dx * dx + dy * dy;
        d2s = d2 << 16;
        // larger short side and larger long side of the two bars
        m  = (w1 < h1) ? w1 : h1;
        lim = (w2 < h2) ? w2 : h2;
        if (lim > m) m = lim;
        bl  = (w1 > h1) ? w1 : h1;
        lim = (w2 > h2) ? w2 : h2;
        if (lim > bl) bl = lim;
        lim = m * c.near_mult;
        if (!(lim * lim < d2s)) return 1'b0;
        lim = m * c.far_mult;
        if (!(d2s < lim * lim)) return 1'b0;
        if (!(bl * bl < d2)) return 1'b0;
        if (!(d2 < LONG_SPAN * LONG_SPAN * bl * bl)) return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            cfg_mirror <= '{ratio_floor: RST_RATIO_FLOOR,
                            ratio_ceil:  RST_RATIO_CEIL,
                            slope_max:   RST_SLOPE_MAX,
                            near_mult:   RST_NEAR_MULT,
                            far_mult:    RST_FAR_MULT};
            pending_pairs.delete();
            o_results <= 0;
            o_pairs   <= 0;
            o_errors  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATIO_FLOOR: cfg_mirror.ratio_floor <= i_cfg_data;
                    CFG_RATIO_CEIL:  cfg_mirror.ratio_ceil  <= i_cfg_data;
                    CFG_SLOPE_MAX:   cfg_mirror.slope_max   <= i_cfg_data;
                    CFG_NEAR_MULT:   cfg_mirror.near_mult   <= i_cfg_data;
                    CFG_FAR_MULT:    cfg_mirror.far_mult    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (i_out_data === 8'd1) o_pairs <= o_pairs + 1;
                if (pending_pairs.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < SHOWN_ERRORS)
                        $display("result word %0d with nothing pending: data %h",
                                 o_results, i_out_data);
                end else begin
                    want = pending_pairs.pop_front();
                    if (i_out_data !== {7'b0, want}) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < SHOWN_ERRORS)
                            $display("result word %0d: is_pair expected %0d, got data %h",
                                     o_results, want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_pairs.insert(pending_pairs.size(),
                                     judge_pair(i_in_data, cfg_mirror));
        end
    end

endmodule

@@ bench/tb_light_bar_pair_match_unit.sv @@
// Stimulus and verdict for light_bar_pair_match_unit.
// Depends on lbpm_pkg, the matcher RTL and lbpm_pair_checker.
`timescale 1ns / 1ps

module tb_light_bar_pair_match_unit;
    import lbpm_pkg::*;

    localparam int CW = 16;
    // word field positions, first rectangle in the low bits
    localparam int FIRST_X   = 0;
    localparam int FIRST_W   = 2;
    localparam int SECOND_X  = 4;
    localparam int SECOND_Y  = 5;
    localparam int SECOND_H  = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [8*CW-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    int words_sent = 0;
    int results_seen;
    int pairs_seen;
    int mismatches;

    always #5 i_clk = ~i_clk;

    light_bar_pair_match_unit #(.COORD_WIDTH(CW)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lbpm_pair_checker #(.CW(CW)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_results   (results_seen),
        .o_pairs     (pairs_seen),
        .o_errors    (mismatches)
    );

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [8*CW-1:0] make_word(
        input logic [15:0] x1, y1, w1, h1, x2, y2, w2, h2);
        return {h2, w2, y2, x2, h1, w1, y1, x1};
    endfunction

    // plausible bar pair: similar bars, spacing around the long side, small tilt
    function automatic logic [8*CW-1:0] candidate_pair();
        int s1, l1, s2, l2, big, dx, dy, x1, y1, tmp;
        logic [15:0] w1, h1, w2, h2;
        s1 = $urandom_range(8, 400);
        l1 = s1 * $urandom_range(2, 5) + $urandom_range(0, 15);
        s2 = s1 + $urandom_range(0, s1 / 3) - s1 / 6;
        l2 = l1 + $urandom_range(0, l1 / 3) - l1 / 6;
        if ($urandom_range(0, 7) == 0) begin
            s2 = $urandom_range(1, 2000);
            l2 = $urandom_range(1, 4000);
        end
        big = (l1 > l2) ? l1 : l2;
        dx = $urandom_range(big / 2, big * 5);
        dy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, dx) : $urandom_range(0, dx / 3);
        x1 = $urandom_range(0, 65535 - dx);
        y1 = $urandom_range(0, 65535 - dy);
        if ($urandom_range(0, 1)) begin w1 = 16'(s1); h1 = 16'(l1); end
        else begin w1 = 16'(l1); h1 = 16'(s1); end
        if ($urandom_range(0, 1)) begin w2 = 16'(s2); h2 = 16'(l2); end
        else begin w2 = 16'(l2); h2 = 16'(s2); end
        // second bar left or right, above or below
        tmp = $urandom_range(0, 3);
        return make_word(16'(tmp[0] ? x1 + dx : x1), 16'(tmp[1] ? y1 + dy : y1), w1, h1,
                         16'(tmp[0] ? x1 : x1 + dx), 16'(tmp[1] ? y1 : y1 + dy), w2, h2);
    endfunction

    function automatic logic [8*CW-1:0] random_item();
        logic [8*CW-1:0] w;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return {$urandom, $urandom, $urandom, $urandom};
        w = candidate_pair();
        if (r == 1) begin
            case ($urandom_range(0, 3))
                0: w[FIRST_W*CW +: CW] = '0;
                1: w[SECOND_H*CW +: CW] = '0;
                2: w[SECOND_X*CW +: CW] = w[FIRST_X*CW +: CW];
                default: w[SECOND_Y*CW +: CW] = CW'($urandom);
            endcase
        end
        return w;
    endfunction

    // call at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic [8*CW-1:0] w);
        int gap;
        gap = (words_sent % 200 < 60) ? 0 : idle_span();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(random_item());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_seen != words_sent) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] ar_min, ar_max, slope, lo_mul, hi_mul,
                                input bit poke_unused);
        cfg_write(CFG_RATIO_FLOOR, ar_min);
        cfg_write(CFG_RATIO_CEIL, ar_max);
        cfg_write(CFG_SLOPE_MAX, slope);
        cfg_write(CFG_NEAR_MULT, lo_mul);
        cfg_write(CFG_FAR_MULT, hi_mul);
        if (poke_unused) cfg_write(CFG_IDX_UNUSED, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // result side: random back-pressure, calm stretches, one long hold-off
    int sink_gap = 0;
    int sink_cycle = 0;
    bit long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_axis_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!long_hold_done && results_seen >= 400) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 149;
            long_hold_done <= 1'b1;
        end else if ((sink_cycle / 400) % 3 != 0 && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            sink_gap <= idle_span();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values; bars 64x256 px unless noted
        send_word(make_word(1000, 2000, 64, 256, 1400, 2000, 64, 256));
        send_word(make_word(1000, 2000, 256, 64, 600, 2000, 256, 64));
        send_word(make_word(1000, 2000, 0, 256, 1400, 2000, 64, 256));
        send_word(make_word(1000, 2000, 64, 256, 1400, 2000, 64, 0));
        send_word(make_word(1000, 2000, 64, 256, 1000, 2000, 64, 256));
        send_word(make_word(1000, 2000, 64, 256, 1000, 2400, 64, 256));
        // slope right at the limit, then one step over
        send_word(make_word(1000, 2000, 64, 256, 1256, 2077, 64, 256));
        send_word(make_word(1000, 2000, 64, 256, 1256, 2078, 64, 256));
        // distance equal to the long side
        send_word(make_word(1000, 2000, 64, 256, 1256, 2000, 64, 256));
        // distance at four long sides, then just inside
        send_word(make_word(1000, 2000, 200, 256, 2024, 2000, 200, 256));
        send_word(make_word(1000, 2000, 200, 256, 2023, 2000, 200, 256));
        // distance at the low multiple of the short side, then just past
        send_word(make_word(1000, 2000, 64, 100, 1128, 2000, 64, 100));
        send_word(make_word(1000, 2000, 64, 100, 1129, 2000, 64, 100));
        // distance at the high multiple, then just inside
        send_word(make_word(1000, 2000, 64, 256, 1512, 2000, 64, 256));
        send_word(make_word(1000, 2000, 64, 256, 1511, 2000, 64, 256));
        // area ratio far too small
        send_word(make_word(1000, 2000, 64, 256, 1400, 2000, 16, 64));
        send_word({8{16'hFFFF}});
        send_word('0);
        send_word(make_word(0, 32768, 30000, 30000, 65535, 32768, 30000, 30000));
        send_word(make_word(65535, 0, 65535, 65535, 0, 0, 65535, 65535));
        send_random(300);

        drain();
        program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        send_random(250);

        drain();
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_random(60);

        drain();
        program_regs(CFG_W'($urandom_range(0, 32768)), CFG_W'($urandom_range(40000, 65535)),
                     CFG_W'($urandom_range(0, 512)), CFG_W'($urandom_range(0, 1024)),
                     CFG_W'($urandom_range(1024, 4096)), 1'b1);
        send_random(200);

        drain();
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_random(40);

        drain();
        program_regs(RST_RATIO_FLOOR, RST_RATIO_CEIL, RST_SLOPE_MAX,
                     RST_NEAR_MULT, RST_FAR_MULT, 1'b1);
        send_random(230);

        drain();
        // catch any stray result words after the last expected one
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bar pair words across six register settings,", words_sent);
        $display("%0d result words seen, %0d of them matched pairs.", results_seen, pairs_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lbpm_pkg.sv
rtl/core/lbpm_datapath.sv
rtl/core/light_bar_pair_match_unit.sv
rtl/core/lbpm_chk.sv
bench/lbpm_pair_checker.sv
bench/tb_light_bar_pair_match_unit.sv
